// ----- rtl/hrs_pkg.sv -----
// ----------------------------------------------------------------------------
// hrs_pkg: shared types and constants
// Payload structs, fixed-point limits and operation codes of the R/S
// Hurst window estimator.
// ----------------------------------------------------------------------------
package hrs_pkg;

  typedef struct packed {
    logic               req_type;
    logic signed [23:0] sample;
  } hrs_in_t;

  typedef struct packed {
    logic [15:0] hurst;
    logic [26:0] range_ratio;
    logic [10:0] fill_count;
    logic        trending;
    logic        updated;
    logic        regime_change;
    logic [15:0] previous_hurst;
    logic [31:0] change_total;
  } hrs_out_t;

  // Request types
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [1:0] REG_MIN_FILL      = 2'd1;
  localparam logic [1:0] REG_NOTIFY_ENABLE = 2'd2;

  localparam int          ADDR_BITS  = 10;
  localparam logic [10:0] WIN_MAX    = 11'd1024;
  localparam logic [15:0] HALF_Q16   = 16'd32768;
  localparam logic [15:0] HURST_LOW  = 16'd655;
  localparam logic [15:0] HURST_HIGH = 16'd64880;
  localparam logic [26:0] RATIO_MAX  = 27'h7FF_FFFF;

  // Shared unit operations
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_SQRT = 2'd1;
  localparam logic [1:0] OP_DIV  = 2'd2;
  localparam logic [1:0] OP_HLOG = 2'd3;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } it_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } it_rsp_t;

endpackage

// ----- rtl/hrs_ram.sv -----
// ----------------------------------------------------------------------------
// hrs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hrs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/hrs_iter.sv -----
// ----------------------------------------------------------------------------
// hrs_iter: shared iterative arithmetic unit
// Serial multiply, digit-by-digit square root and restoring division at one
// step per cycle, and the repeated-squaring log2, each step a squaring then a bit.
// ----------------------------------------------------------------------------
module hrs_iter (
  input  logic            clk,
  input  logic            rst_n,
  input  hrs_pkg::it_req_t req,
  input  logic [67:0]     opa,
  input  logic [33:0]     opb,
  output hrs_pkg::it_rsp_t rsp,
  output logic [67:0]     res
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        phase_r, phase_nxt;
  logic [67:0] a_r, a_nxt;
  logic [33:0] b_r, b_nxt;
  logic [67:0] acc_r, acc_nxt;
  logic [31:0] q_r, q_nxt;
  logic        ovf_r, ovf_nxt;

  logic [36:0] sq_rem;
  logic [36:0] sq_trial;
  logic [34:0] dv_rem;
  logic [31:0] lg_m;
  logic [63:0] lg_sq;
  logic        last;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    q_nxt     = q_r;
    ovf_nxt   = ovf_r;
    sq_rem    = {acc_r[34:0], a_r[67:66]};
    sq_trial  = {1'b0, b_r, 2'b01};
    dv_rem    = {acc_r[33:0], a_r[63]};
    lg_m      = acc_r[61:30];
    lg_sq     = a_r[31:0] * a_r[31:0];
    last      = (cnt_r == 6'd0);

    if (req.start) begin
      busy_nxt  = 1'b1;
      op_nxt    = req.op;
      phase_nxt = 1'b0;
      a_nxt     = opa;
      b_nxt     = (req.op == hrs_pkg::OP_SQRT) ? 34'd0 : opb;
      acc_nxt   = '0;
      q_nxt     = '0;
      ovf_nxt   = 1'b0;
      unique case (req.op)
        hrs_pkg::OP_MUL:  cnt_nxt = 6'd33;
        hrs_pkg::OP_SQRT: cnt_nxt = 6'd33;
        hrs_pkg::OP_DIV:  cnt_nxt = 6'd63;
        hrs_pkg::OP_HLOG: cnt_nxt = 6'd15;
        default:          cnt_nxt = 6'd0;
      endcase
    end else if (busy_r) begin
      unique case (op_r)
        hrs_pkg::OP_MUL: begin
          acc_nxt = {acc_r[66:0], 1'b0} + (b_r[33] ? a_r : 68'd0);
          b_nxt   = {b_r[32:0], 1'b0};
        end
        hrs_pkg::OP_SQRT: begin
          a_nxt = {a_r[65:0], 2'b00};
          if (sq_rem >= sq_trial) begin
            acc_nxt = {31'd0, sq_rem - sq_trial};
            b_nxt   = {b_r[32:0], 1'b1};
          end else begin
            acc_nxt = {31'd0, sq_rem};
            b_nxt   = {b_r[32:0], 1'b0};
          end
        end
        hrs_pkg::OP_DIV: begin
          a_nxt   = {a_r[66:0], 1'b0};
          ovf_nxt = ovf_r | q_r[31];
          if (dv_rem >= {1'b0, b_r}) begin
            acc_nxt = {33'd0, dv_rem - {1'b0, b_r}};
            q_nxt   = {q_r[30:0], 1'b1};
          end else begin
            acc_nxt = {33'd0, dv_rem};
            q_nxt   = {q_r[30:0], 1'b0};
          end
        end
        hrs_pkg::OP_HLOG: begin
          if (!phase_r) begin
            acc_nxt = {4'd0, lg_sq};
          end else if (lg_m[31]) begin
            a_nxt = {37'd0, lg_m[31:1]};
            q_nxt = {q_r[30:0], 1'b1};
          end else begin
            a_nxt = {36'd0, lg_m};
            q_nxt = {q_r[30:0], 1'b0};
          end
          phase_nxt = ~phase_r;
        end
        default: ;
      endcase
      // each log2 step has a squaring phase and then a bit phase; the count moves on the bit phase
      if (op_r != hrs_pkg::OP_HLOG || phase_r) begin
        if (last) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r    <= op_nxt;
    cnt_r   <= cnt_nxt;
    phase_r <= phase_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    acc_r   <= acc_nxt;
    q_r     <= q_nxt;
    ovf_r   <= ovf_nxt;
  end

  always_comb begin
    unique case (op_r)
      hrs_pkg::OP_MUL:  res = acc_r;
      hrs_pkg::OP_SQRT: res = {34'd0, b_r};
      hrs_pkg::OP_DIV:  res = {36'd0, q_r};
      hrs_pkg::OP_HLOG: res = {52'd0, q_r[15:0]};
      default:          res = '0;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;

endmodule

// ----- rtl/hurst_rs_window_estimator_unit.sv -----
// ----------------------------------------------------------------------------
// hurst_rs_window_estimator_unit: rescaled-range Hurst estimator
// Sliding window of Q12.12 samples, R/S over the whole window and its newest
// half, Hurst estimate as a Q0.16 log2 of their ratio with crossing flags.
// ----------------------------------------------------------------------------
// Each sample transaction enters a window of up to 1024 samples held in a
// RAM. Once the fill reaches min_fill, a sequencer walks the full window (n
// samples) and then its newest half, each segment in two RAM passes (sums,
// then the cumulative deviation range), and drives one shared iterative unit
// for the variance products, the square root and the range/root division.
// The Hurst log2 then takes one more division and sixteen squarings on the
// same unit. The two passes read the RAM one sample per cycle and the shared
// unit retires one bit per cycle in its multiply, root and divide steps. A
// sample below the fill threshold or a clear transaction skips the R/S work
// and goes to the output register; a configuration write is taken in idle and
// gives no result. The input and configuration ports take no new transaction
// while an item is in work. The result sits in an output register until taken;
// the block returns to idle only once the previous result has left that register.
// ----------------------------------------------------------------------------
module hurst_rs_window_estimator_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hrs_pkg::hrs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hrs_pkg::hrs_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [10:0]       cfg_data
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CHECK  = 4'd1;
  localparam logic [3:0] ST_SEG    = 4'd2;
  localparam logic [3:0] ST_P1     = 4'd3;
  localparam logic [3:0] ST_MQ     = 4'd4;
  localparam logic [3:0] ST_SS     = 4'd5;
  localparam logic [3:0] ST_SQ     = 4'd6;
  localparam logic [3:0] ST_P2     = 4'd7;
  localparam logic [3:0] ST_DIV    = 4'd8;
  localparam logic [3:0] ST_SEGEND = 4'd9;
  localparam logic [3:0] ST_HUR    = 4'd10;
  localparam logic [3:0] ST_HDIV   = 4'd11;
  localparam logic [3:0] ST_HLOG   = 4'd12;
  localparam logic [3:0] ST_FIN    = 4'd13;
  localparam logic [3:0] ST_DONE   = 4'd14;

  logic [3:0]         state_r, state_nxt;
  logic [10:0]        wl_r, wl_nxt;
  logic [10:0]        mf_r, mf_nxt;
  logic               ne_r, ne_nxt;
  logic [9:0]         oldest_r, oldest_nxt;
  logic [10:0]        held_r, held_nxt;
  logic [15:0]        est_r, est_nxt;
  logic [26:0]        ratio_r, ratio_nxt;
  logic [31:0]        ccount_r, ccount_nxt;
  logic               upd_r, upd_nxt;
  logic               chg_r, chg_nxt;
  logic [15:0]        prev_r, prev_nxt;
  logic               seg_r, seg_nxt;
  logic [10:0]        idx_r, idx_nxt;
  logic               rd_v_r, rd_v_nxt;
  logic signed [35:0] sum_r, sum_nxt;
  logic [56:0]        sq_r, sq_nxt;
  logic [67:0]        mq_r, mq_nxt;
  logic [33:0]        root_r, root_nxt;
  logic signed [47:0] cum_r, cum_nxt;
  logic signed [47:0] hi_r, hi_nxt;
  logic signed [47:0] lo_r, lo_nxt;
  logic [26:0]        rs_cur_r, rs_cur_nxt;
  logic [26:0]        rsn_r, rsn_nxt;
  logic [26:0]        rsh_r, rsh_nxt;
  logic               out_valid_r, out_valid_nxt;
  hrs_pkg::hrs_out_t  out_r, out_nxt;

  hrs_pkg::it_req_t   it_req;
  hrs_pkg::it_rsp_t   it_rsp;
  logic [67:0]        it_opa;
  logic [33:0]        it_opb;
  logic [67:0]        it_res;

  logic               ram_we;
  logic [9:0]         ram_waddr;
  logic [9:0]         ram_raddr;
  logic [23:0]        ram_rdata;

  logic [10:0]        cap;
  logic [10:0]        half;
  logic [10:0]        seg_len;
  logic [9:0]         seg_off;
  logic               issuing;
  logic signed [24:0] mul_sel;
  logic signed [48:0] prod;
  logic signed [36:0] dev;
  logic signed [47:0] cum_step;
  logic [33:0]        abs_s;
  logic [35:0]        neg_s;
  logic [47:0]        range;
  logic [31:0]        quo;
  logic [15:0]        hl;

  hrs_ram #(
    .WIDTH (24),
    .DEPTH (1024)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_data.sample),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  hrs_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (it_req),
    .opa   (it_opa),
    .opb   (it_opb),
    .rsp   (it_rsp),
    .res   (it_res)
  );

  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Segment geometry: full window first, then its newest half
  assign cap     = (wl_r > hrs_pkg::WIN_MAX) ? hrs_pkg::WIN_MAX : wl_r;
  assign half    = {1'b0, held_r[10:1]};
  assign seg_len = seg_r ? half : held_r;
  assign seg_off = seg_r ? (held_r[9:0] - half[9:0]) : 10'd0;
  assign issuing = (idx_r < seg_len);

  assign ram_raddr = oldest_r + seg_off + idx_r[9:0];
  assign ram_waddr = oldest_r + held_r[9:0];
  assign ram_we    = (state_r == ST_IDLE) && in_valid && in_ready &&
                     (in_data.req_type == hrs_pkg::REQ_SAMPLE) && (cap != 11'd0);

  // One multiplier serves both passes: x*x for the sums, n*x for deviations
  assign mul_sel  = (state_r == ST_P1) ? {ram_rdata[23], ram_rdata}
                                       : $signed({14'd0, seg_len});
  assign prod     = $signed(ram_rdata) * mul_sel;
  assign dev      = $signed({prod[35], prod[35:0]}) - $signed({sum_r[35], sum_r});
  assign cum_step = cum_r + {{11{dev[36]}}, dev};

  assign neg_s = 36'd0 - sum_r;
  assign abs_s = sum_r[35] ? neg_s[33:0] : sum_r[33:0];
  assign range = hi_r - lo_r;
  assign quo   = it_res[31:0];
  assign hl    = it_res[15:0];

  always_comb begin
    state_nxt     = state_r;
    wl_nxt        = wl_r;
    mf_nxt        = mf_r;
    ne_nxt        = ne_r;
    oldest_nxt    = oldest_r;
    held_nxt      = held_r;
    est_nxt       = est_r;
    ratio_nxt     = ratio_r;
    ccount_nxt    = ccount_r;
    upd_nxt       = upd_r;
    chg_nxt       = chg_r;
    prev_nxt      = prev_r;
    seg_nxt       = seg_r;
    idx_nxt       = idx_r;
    rd_v_nxt      = 1'b0;
    sum_nxt       = sum_r;
    sq_nxt        = sq_r;
    mq_nxt        = mq_r;
    root_nxt      = root_r;
    cum_nxt       = cum_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    rs_cur_nxt    = rs_cur_r;
    rsn_nxt       = rsn_r;
    rsh_nxt       = rsh_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    it_req.start  = 1'b0;
    it_req.op     = hrs_pkg::OP_MUL;
    it_opa        = '0;
    it_opb        = '0;

    // drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          // a write to a known register also empties the window
          case (cfg_index)
            hrs_pkg::REG_WINDOW_LENGTH: wl_nxt = cfg_data;
            hrs_pkg::REG_MIN_FILL:      mf_nxt = cfg_data;
            hrs_pkg::REG_NOTIFY_ENABLE: ne_nxt = cfg_data[0];
            default: ;
          endcase
          if (cfg_index == hrs_pkg::REG_WINDOW_LENGTH ||
              cfg_index == hrs_pkg::REG_MIN_FILL ||
              cfg_index == hrs_pkg::REG_NOTIFY_ENABLE) begin
            oldest_nxt = '0;
            held_nxt   = '0;
            est_nxt    = hrs_pkg::HALF_Q16;
            ratio_nxt  = '0;
          end
        end else if (in_valid) begin
          upd_nxt  = 1'b0;
          chg_nxt  = 1'b0;
          prev_nxt = '0;
          if (in_data.req_type == hrs_pkg::REQ_CLEAR) begin
            oldest_nxt = '0;
            held_nxt   = '0;
            est_nxt    = hrs_pkg::HALF_Q16;
            ratio_nxt  = '0;
            state_nxt  = ST_DONE;
          end else begin
            // full window: advance the oldest pointer instead of growing
            if (cap != 11'd0) begin
              if (held_r < cap) begin
                held_nxt = held_r + 11'd1;
              end else begin
                oldest_nxt = oldest_r + 10'd1;
              end
            end
            state_nxt = ST_CHECK;
          end
        end
      end

      ST_CHECK: begin
        if (held_r >= mf_r) begin
          seg_nxt   = 1'b0;
          state_nxt = ST_SEG;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_SEG: begin
        if (seg_len < 11'd2) begin
          rs_cur_nxt = '0;
          state_nxt  = ST_SEGEND;
        end else begin
          idx_nxt   = '0;
          sum_nxt   = '0;
          sq_nxt    = '0;
          state_nxt = ST_P1;
        end
      end

      ST_P1: begin
        if (issuing) begin
          idx_nxt  = idx_r + 11'd1;
          rd_v_nxt = 1'b1;
        end
        if (rd_v_r) begin
          sum_nxt = sum_r + {{12{ram_rdata[23]}}, ram_rdata};
          sq_nxt  = sq_r + {10'd0, prod[46:0]};
        end
        if (!issuing && !rd_v_r) begin
          it_req.start = 1'b1;
          it_req.op    = hrs_pkg::OP_MUL;
          it_opa       = {11'd0, sq_r};
          it_opb       = {23'd0, seg_len};
          state_nxt    = ST_MQ;
        end
      end

      ST_MQ: begin
        if (it_rsp.done) begin
          mq_nxt       = it_res;
          it_req.start = 1'b1;
          it_req.op    = hrs_pkg::OP_MUL;
          it_opa       = {34'd0, abs_s};
          it_opb       = abs_s;
          state_nxt    = ST_SS;
        end
      end

      ST_SS: begin
        if (it_rsp.done) begin
          it_req.start = 1'b1;
          it_req.op    = hrs_pkg::OP_SQRT;
          it_opa       = mq_r - it_res;
          state_nxt    = ST_SQ;
        end
      end

      ST_SQ: begin
        if (it_rsp.done) begin
          root_nxt = it_res[33:0];
          if (it_res[33:0] == 34'd0) begin
            rs_cur_nxt = '0;
            state_nxt  = ST_SEGEND;
          end else begin
            idx_nxt   = '0;
            cum_nxt   = '0;
            hi_nxt    = '0;
            lo_nxt    = '0;
            state_nxt = ST_P2;
          end
        end
      end

      ST_P2: begin
        if (issuing) begin
          idx_nxt  = idx_r + 11'd1;
          rd_v_nxt = 1'b1;
        end
        if (rd_v_r) begin
          cum_nxt = cum_step;
          if (cum_step > hi_r) hi_nxt = cum_step;
          if (cum_step < lo_r) lo_nxt = cum_step;
        end
        if (!issuing && !rd_v_r) begin
          it_req.start = 1'b1;
          it_req.op    = hrs_pkg::OP_DIV;
          it_opa       = {4'd0, range, 16'd0};
          it_opb       = root_r;
          state_nxt    = ST_DIV;
        end
      end

      ST_DIV: begin
        if (it_rsp.done) begin
          // saturate once the integer part needs more than eleven bits
          if (it_rsp.ovf || quo[31:27] != 5'd0) begin
            rs_cur_nxt = hrs_pkg::RATIO_MAX;
          end else begin
            rs_cur_nxt = quo[26:0];
          end
          state_nxt = ST_SEGEND;
        end
      end

      ST_SEGEND: begin
        if (!seg_r) begin
          rsn_nxt   = rs_cur_r;
          seg_nxt   = 1'b1;
          state_nxt = ST_SEG;
        end else begin
          rsh_nxt   = rs_cur_r;
          state_nxt = ST_HUR;
        end
      end

      ST_HUR: begin
        if (rsn_r == 27'd0 || rsh_r == 27'd0 || half < 11'd2) begin
          est_nxt   = hrs_pkg::HALF_Q16;
          state_nxt = ST_FIN;
        end else if (rsn_r <= rsh_r) begin
          est_nxt   = hrs_pkg::HURST_LOW;
          state_nxt = ST_FIN;
        end else if ({1'b0, rsn_r} >= {rsh_r, 1'b0}) begin
          est_nxt   = hrs_pkg::HURST_HIGH;
          state_nxt = ST_FIN;
        end else begin
          it_req.start = 1'b1;
          it_req.op    = hrs_pkg::OP_DIV;
          it_opa       = {11'd0, rsn_r, 30'd0};
          it_opb       = {7'd0, rsh_r};
          state_nxt    = ST_HDIV;
        end
      end

      ST_HDIV: begin
        if (it_rsp.done) begin
          it_req.start = 1'b1;
          it_req.op    = hrs_pkg::OP_HLOG;
          it_opa       = {36'd0, quo};
          state_nxt    = ST_HLOG;
        end
      end

      ST_HLOG: begin
        if (it_rsp.done) begin
          if (hl < hrs_pkg::HURST_LOW) begin
            est_nxt = hrs_pkg::HURST_LOW;
          end else if (hl > hrs_pkg::HURST_HIGH) begin
            est_nxt = hrs_pkg::HURST_HIGH;
          end else begin
            est_nxt = hl;
          end
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        // est_r holds the new estimate, prev_r already holds the old one
        upd_nxt   = 1'b1;
        ratio_nxt = rsn_r;
        if (((prev_r > hrs_pkg::HALF_Q16) != (est_r > hrs_pkg::HALF_Q16)) && ne_r) begin
          chg_nxt    = 1'b1;
          ccount_nxt = ccount_r + 32'd1;
        end else begin
          prev_nxt = '0;
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.hurst          = est_r;
          out_nxt.range_ratio    = ratio_r;
          out_nxt.fill_count     = held_r;
          out_nxt.trending       = (est_r > hrs_pkg::HALF_Q16);
          out_nxt.updated        = upd_r;
          out_nxt.regime_change  = chg_r;
          out_nxt.previous_hurst = prev_r;
          out_nxt.change_total   = ccount_r;
          out_valid_nxt          = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // hold the estimate before the update for the crossing check
    if (state_r == ST_CHECK && held_r >= mf_r) begin
      prev_nxt = est_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wl_r        <= 11'd64;
      mf_r        <= 11'd16;
      ne_r        <= 1'b0;
      oldest_r    <= '0;
      held_r      <= '0;
      est_r       <= hrs_pkg::HALF_Q16;
      ratio_r     <= '0;
      ccount_r    <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wl_r        <= wl_nxt;
      mf_r        <= mf_nxt;
      ne_r        <= ne_nxt;
      oldest_r    <= oldest_nxt;
      held_r      <= held_nxt;
      est_r       <= est_nxt;
      ratio_r     <= ratio_nxt;
      ccount_r    <= ccount_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    upd_r    <= upd_nxt;
    chg_r    <= chg_nxt;
    prev_r   <= prev_nxt;
    seg_r    <= seg_nxt;
    idx_r    <= idx_nxt;
    sum_r    <= sum_nxt;
    sq_r     <= sq_nxt;
    mq_r     <= mq_nxt;
    root_r   <= root_nxt;
    cum_r    <= cum_nxt;
    hi_r     <= hi_nxt;
    lo_r     <= lo_nxt;
    rs_cur_r <= rs_cur_nxt;
    rsn_r    <= rsn_nxt;
    rsh_r    <= rsh_nxt;
    out_r    <= out_nxt;
  end

endmodule
